### hdl/mlp_pkg.sv
// Shared types, constants and the rounding function of the network classifier.
package mlp_pkg;

    // Default network sizes, handed to the top level parameters.
    localparam int DEF_NUM_FEATURES = 5;
    localparam int DEF_HIDDEN_ONE   = 15;
    localparam int DEF_HIDDEN_TWO   = 5;
    localparam int DEF_NUM_CLASSES  = 4;
    localparam int DEF_WEIGHT_DEPTH = 256;

    // Fixed widths of the data path.
    localparam int WORD_W           = 16;
    localparam int PROD_W           = 2 * WORD_W;
    localparam int ACC_W            = 40;
    localparam int ACT_DEPTH        = 16;
    localparam int ACT_IDX_W        = 4;
    localparam int CARRIED_FEATURES = 5;
    // Read address width: covers every packed offset and every store depth in range.
    localparam int RADDR_W          = 11;

    // Q8.8 one, used as the multiplicand of the bias term.
    localparam logic signed [WORD_W-1:0] ACT_ONE = 16'sd256;

    // Command codes of an input word.
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CARRIED_FEATURES-1:0][WORD_W-1:0] feat_vec_t;

    // One multiply-accumulate term issued by the sequencer.
    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic                 final_l;
        logic                 src_bank;
        logic [ACT_IDX_W-1:0] row;
        logic [ACT_IDX_W-1:0] col;
        logic [RADDR_W-1:0]   addr;
    } issue_t;

    // Status returned by the data path.
    typedef struct packed {
        logic                 busy;
        logic [ACT_IDX_W-1:0] best_idx;
    } dp_status_t;

    // Round half towards plus infinity, then saturate to Q8.8.
    function automatic word_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]    v;
        logic signed [ACC_W-8:0]  q;
        word_t                    r;
        v = (ACC_W+1)'(acc) + 41'sd128;
        q = (ACC_W-7)'(v >>> 8);
        if (q > 33'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (q < -33'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = q[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/mlp_dp.sv
// Data path: weight memory, activation banks, multiply-accumulate pipeline and argmax.
module mlp_dp
    import mlp_pkg::*;
#(
    parameter int NUM_FEATURES = DEF_NUM_FEATURES,
    parameter int WEIGHT_DEPTH = DEF_WEIGHT_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [7:0]  wr_addr,
    input  word_t       wr_data,
    input  logic        feat_en,
    input  feat_vec_t   feats,
    input  issue_t      issue,
    output dp_status_t  status
);

    localparam int WIDX_W = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
    localparam int WEXT_W = WIDX_W + 8;

    typedef struct packed {
        logic                 valid;
        logic                 first;
        logic                 last;
        logic                 final_l;
        logic                 dst;
        logic [ACT_IDX_W-1:0] row;
    } tag_t;

    word_t                 wmem [WEIGHT_DEPTH];
    word_t                 bank0 [ACT_DEPTH];
    word_t                 bank1 [ACT_DEPTH];
    word_t                 feat_ext [ACT_DEPTH];

    logic [WEXT_W-1:0]     wr_ext;
    logic                  wr_ok;
    logic                  rd_ok;

    word_t                 w_rd_reg;
    word_t                 act_rd_reg;
    logic                  oor_reg;
    word_t                 w_op;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    word_t                 res_reg;
    word_t                 best_val_reg;
    logic [ACT_IDX_W-1:0]  best_idx_reg;

    tag_t                  s1_reg;
    tag_t                  s2_reg;
    tag_t                  s3_reg;
    tag_t                  s4_reg;
    tag_t                  s0_tag;

    // Load address check; addresses beyond the store are dropped.
    assign wr_ext = WEXT_W'(wr_addr);
    assign wr_ok  = wr_en && (wr_ext < WEXT_W'(WEIGHT_DEPTH));
    // Reads beyond the store give zero.
    assign rd_ok  = issue.addr < RADDR_W'(WEIGHT_DEPTH);

    // Features as seen by the first layer; positions not carried read as zero.
    genvar gi;
    generate
        for (gi = 0; gi < ACT_DEPTH; gi++)
        begin : g_feat
            if (gi < CARRIED_FEATURES && gi < NUM_FEATURES)
            begin : g_carried
                assign feat_ext[gi] = word_t'(feats[gi]);
            end
            else
            begin : g_zero
                assign feat_ext[gi] = '0;
            end
        end
    endgenerate

    // Tag of the term entering the pipeline.
    always_comb
    begin
        s0_tag.valid   = issue.valid;
        s0_tag.first   = issue.first;
        s0_tag.last    = issue.last;
        s0_tag.final_l = issue.final_l;
        s0_tag.dst     = ~issue.src_bank;
        s0_tag.row     = issue.row;
    end

    // Weight memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            wmem[wr_ext[WIDX_W-1:0]] <= wr_data;
        end
        w_rd_reg <= wmem[issue.addr[WIDX_W-1:0]];
    end

    // Activation banks: features on a classify word, layer results on commit.
    always_ff @(posedge clk)
    begin
        if (feat_en)
        begin
            for (int i = 0; i < ACT_DEPTH; i++)
            begin
                bank0[i] <= feat_ext[i];
            end
        end
        else if (s4_reg.valid)
        begin
            if (s4_reg.dst)
            begin
                bank1[s4_reg.row] <= res_reg;
            end
            else
            begin
                bank0[s4_reg.row] <= res_reg;
            end
        end
    end

    // Operand fetch, multiply and round stages; the accumulator is in the control block below.
    always_ff @(posedge clk)
    begin
        oor_reg    <= ~rd_ok;
        act_rd_reg <= issue.first ? ACT_ONE :
                      (issue.src_bank ? bank1[issue.col] : bank0[issue.col]);
        prod_reg   <= PROD_W'(w_op) * PROD_W'(act_rd_reg);
        if (s3_reg.valid && s3_reg.last)
        begin
            res_reg <= round_sat(acc_reg);
        end
    end

    assign w_op = oor_reg ? word_t'(0) : w_rd_reg;

    // Pipeline control, accumulator and running maximum of the last layer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_reg       <= '0;
            s4_reg       <= '0;
            acc_reg      <= '0;
            best_val_reg <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            s1_reg       <= s0_tag;
            s2_reg       <= s1_reg;
            s3_reg       <= s2_reg;
            // Only the last term of an output commits a result.
            s4_reg       <= '{valid: s3_reg.valid && s3_reg.last, first: s3_reg.first,
                              last: s3_reg.last, final_l: s3_reg.final_l,
                              dst: s3_reg.dst, row: s3_reg.row};
            if (s2_reg.valid)
            begin
                acc_reg <= s2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
            end
            if (s4_reg.valid && s4_reg.final_l &&
                ((s4_reg.row == '0) || (res_reg > best_val_reg)))
            begin
                best_val_reg <= res_reg;
                best_idx_reg <= s4_reg.row;
            end
        end
    end

    assign status.busy     = s1_reg.valid | s2_reg.valid | s3_reg.valid | s4_reg.valid;
    assign status.best_idx = best_idx_reg;

endmodule

### hdl/mlp_seq.sv
// Microcoded sequencer: control program, step counter, loop counters and result register.
module mlp_seq
    import mlp_pkg::*;
#(
    parameter int NUM_FEATURES = DEF_NUM_FEATURES,
    parameter int HIDDEN_ONE   = DEF_HIDDEN_ONE,
    parameter int HIDDEN_TWO   = DEF_HIDDEN_TWO,
    parameter int NUM_CLASSES  = DEF_NUM_CLASSES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        batch_in,
    input  logic        out_stall,
    input  dp_status_t  status,
    output issue_t      issue,
    output logic        busy,
    output logic        out_valid,
    output logic [1:0]  predicted_class,
    output logic        batch_end
);

    // Packed offsets of the weight store.
    localparam int OFF_W0 = 0;
    localparam int OFF_B0 = OFF_W0 + HIDDEN_ONE * NUM_FEATURES;
    localparam int OFF_W1 = OFF_B0 + HIDDEN_ONE;
    localparam int OFF_B1 = OFF_W1 + HIDDEN_TWO * HIDDEN_ONE;
    localparam int OFF_W2 = OFF_B1 + HIDDEN_TWO;
    localparam int OFF_B2 = OFF_W2 + NUM_CLASSES * HIDDEN_TWO;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_BIAS, ST_MAC, ST_ROW_END, ST_DRAIN, ST_LAYER, ST_OUT
    } step_t;

    typedef enum logic [2:0] {
        C_NEVER, C_NO_START, C_COL_MORE, C_ROW_MORE, C_PIPE_BUSY, C_LAYER_MORE, C_OUT_BUSY
    } cond_t;

    typedef enum logic [1:0] {
        K_NONE, K_BIAS, K_WEIGHT
    } kind_t;

    typedef enum logic [1:0] {
        LY_FIRST, LY_SECOND, LY_THIRD
    } layer_t;

    // One control word: branch condition and target, term issue and counter actions.
    typedef struct packed {
        cond_t cond;
        step_t target;
        kind_t kind;
        logic  arm;
        logic  setup;
        logic  row_inc;
        logic  layer_inc;
        logic  out_load;
    } uword_t;

    // Control program; a step whose condition fails falls through to the next one.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '{cond: C_NEVER, target: ST_IDLE, kind: K_NONE, arm: 1'b0, setup: 1'b0,
              row_inc: 1'b0, layer_inc: 1'b0, out_load: 1'b0};
        unique case (s)
            ST_IDLE:
            begin
                w.cond   = C_NO_START;
                w.target = ST_IDLE;
                w.arm    = 1'b1;
            end
            ST_SETUP:
            begin
                w.setup = 1'b1;
            end
            ST_BIAS:
            begin
                w.kind = K_BIAS;
            end
            ST_MAC:
            begin
                w.kind   = K_WEIGHT;
                w.cond   = C_COL_MORE;
                w.target = ST_MAC;
            end
            ST_ROW_END:
            begin
                w.row_inc = 1'b1;
                w.cond    = C_ROW_MORE;
                w.target  = ST_BIAS;
            end
            ST_DRAIN:
            begin
                w.cond   = C_PIPE_BUSY;
                w.target = ST_DRAIN;
            end
            ST_LAYER:
            begin
                w.layer_inc = 1'b1;
                w.cond      = C_LAYER_MORE;
                w.target    = ST_SETUP;
            end
            ST_OUT:
            begin
                w.out_load = 1'b1;
                w.cond     = C_OUT_BUSY;
                w.target   = ST_OUT;
            end
            default:
            begin
                w.cond = C_NEVER;
            end
        endcase
        return w;
    endfunction

    step_t                 pc_reg;
    step_t                 pc_next;
    layer_t                layer_reg;
    logic [ACT_IDX_W-1:0]  row_reg;
    logic [ACT_IDX_W-1:0]  col_reg;
    logic [RADDR_W-1:0]    waddr_reg;
    logic [RADDR_W-1:0]    baddr_reg;
    logic                  batch_reg;
    logic                  out_valid_reg;
    logic [1:0]            class_reg;
    logic                  batch_end_reg;

    uword_t                uw;
    logic                  cond_true;
    logic                  out_busy;
    logic                  col_last;
    logic                  row_last;
    logic [RADDR_W-1:0]    woff;
    logic [RADDR_W-1:0]    boff;
    logic [ACT_IDX_W-1:0]  ins_m1;
    logic [ACT_IDX_W-1:0]  outs_m1;

    assign uw       = ucode(pc_reg);
    assign out_busy = out_valid_reg & out_stall;
    assign col_last = (col_reg == ins_m1);
    assign row_last = (row_reg == outs_m1);

    // Sizes and offsets of the layer in progress.
    always_comb
    begin
        case (layer_reg)
            LY_FIRST:
            begin
                woff    = RADDR_W'(OFF_W0);
                boff    = RADDR_W'(OFF_B0);
                ins_m1  = ACT_IDX_W'(NUM_FEATURES - 1);
                outs_m1 = ACT_IDX_W'(HIDDEN_ONE - 1);
            end
            LY_SECOND:
            begin
                woff    = RADDR_W'(OFF_W1);
                boff    = RADDR_W'(OFF_B1);
                ins_m1  = ACT_IDX_W'(HIDDEN_ONE - 1);
                outs_m1 = ACT_IDX_W'(HIDDEN_TWO - 1);
            end
            default:
            begin
                woff    = RADDR_W'(OFF_W2);
                boff    = RADDR_W'(OFF_B2);
                ins_m1  = ACT_IDX_W'(HIDDEN_TWO - 1);
                outs_m1 = ACT_IDX_W'(NUM_CLASSES - 1);
            end
        endcase
    end

    // Branch condition decode and next step.
    always_comb
    begin
        unique case (uw.cond)
            C_NEVER:      cond_true = 1'b0;
            C_NO_START:   cond_true = ~start;
            C_COL_MORE:   cond_true = ~col_last;
            C_ROW_MORE:   cond_true = ~row_last;
            C_PIPE_BUSY:  cond_true = status.busy;
            C_LAYER_MORE: cond_true = (layer_reg != LY_THIRD);
            C_OUT_BUSY:   cond_true = out_busy;
            default:      cond_true = 1'b0;
        endcase
        pc_next = cond_true ? uw.target : step_t'(pc_reg + 3'd1);
    end

    // Term issued to the data path this cycle.
    always_comb
    begin
        issue.valid    = (uw.kind != K_NONE);
        issue.first    = (uw.kind == K_BIAS);
        issue.last     = (uw.kind == K_WEIGHT) && col_last;
        issue.final_l  = (layer_reg == LY_THIRD);
        issue.src_bank = layer_reg[0];
        issue.row      = row_reg;
        issue.col      = col_reg;
        issue.addr     = (uw.kind == K_BIAS) ? baddr_reg : waddr_reg;
    end

    // Step counter, loop counters and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_IDLE;
            layer_reg     <= LY_FIRST;
            row_reg       <= '0;
            col_reg       <= '0;
            waddr_reg     <= '0;
            baddr_reg     <= '0;
            batch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            class_reg     <= '0;
            batch_end_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (uw.arm && start)
            begin
                layer_reg <= LY_FIRST;
                batch_reg <= batch_in;
            end
            if (uw.setup)
            begin
                waddr_reg <= woff;
                baddr_reg <= boff;
                row_reg   <= '0;
            end
            if (uw.kind == K_BIAS)
            begin
                baddr_reg <= baddr_reg + RADDR_W'(1);
                col_reg   <= '0;
            end
            else if (uw.kind == K_WEIGHT)
            begin
                waddr_reg <= waddr_reg + RADDR_W'(1);
                col_reg   <= col_reg + ACT_IDX_W'(1);
            end
            if (uw.row_inc)
            begin
                row_reg <= row_reg + ACT_IDX_W'(1);
            end
            if (uw.layer_inc && (layer_reg != LY_THIRD))
            begin
                layer_reg <= layer_t'(layer_reg + 2'd1);
            end
            if (uw.out_load && !out_busy)
            begin
                out_valid_reg <= 1'b1;
                class_reg     <= status.best_idx[1:0];
                batch_end_reg <= batch_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign busy            = (pc_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign predicted_class = class_reg;
    assign batch_end       = batch_end_reg;

endmodule

### hdl/mlp_classifier_inference.sv
// Top level of the three-layer linear network classifier.
// A load word (cmd low) writes one signed Q8.8 weight or bias into the weight store in the
// cycle it is accepted and gives no result; the store is packed row-major as w0, b0, w1, b1,
// w2, b2, and every entry a classify reads must have been loaded first. A classify word
// (cmd high) runs all three layers through one shared multiply-accumulate unit and returns
// the index of the largest final output, lowest index on a tie, with last_in_batch copied
// to batch_end. The rate is set by that unit taking one stored term per cycle: each output
// issues its bias term, then one term per input, then a row turn-round step, and each layer
// adds a set-up step, a pipeline drain and a layer step; the result of a classify is valid
// once the last layer has drained, and the next word can be taken once the result is loaded.
// If an earlier result is still stalled at the output, the new one waits for it to be taken.
// in_stall stays high while a classify is at work; a finished result may wait at the
// output while the next word is accepted.
module mlp_classifier_inference
    import mlp_pkg::*;
#(
    parameter int NUM_FEATURES = DEF_NUM_FEATURES,
    parameter int HIDDEN_ONE   = DEF_HIDDEN_ONE,
    parameter int HIDDEN_TWO   = DEF_HIDDEN_TWO,
    parameter int NUM_CLASSES  = DEF_NUM_CLASSES,
    parameter int WEIGHT_DEPTH = DEF_WEIGHT_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  weight_addr,
    input  word_t       weight_value,
    input  word_t       feature_0,
    input  word_t       feature_1,
    input  word_t       feature_2,
    input  word_t       feature_3,
    input  word_t       feature_4,
    input  logic        last_in_batch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  predicted_class,
    output logic        batch_end
);

    logic        in_accept;
    logic        load_en;
    logic        start;
    feat_vec_t   feats;
    issue_t      issue;
    dp_status_t  status;

    // Word acceptance and command decode.
    assign in_accept = in_valid & ~in_stall;
    assign load_en   = in_accept & (cmd == CMD_LOAD);
    assign start     = in_accept & (cmd == CMD_CLASSIFY);

    assign feats[0] = feature_0;
    assign feats[1] = feature_1;
    assign feats[2] = feature_2;
    assign feats[3] = feature_3;
    assign feats[4] = feature_4;

    mlp_seq #(
        .NUM_FEATURES (NUM_FEATURES),
        .HIDDEN_ONE   (HIDDEN_ONE),
        .HIDDEN_TWO   (HIDDEN_TWO),
        .NUM_CLASSES  (NUM_CLASSES)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .batch_in        (last_in_batch),
        .out_stall       (out_stall),
        .status          (status),
        .issue           (issue),
        .busy            (in_stall),
        .out_valid       (out_valid),
        .predicted_class (predicted_class),
        .batch_end       (batch_end)
    );

    mlp_dp #(
        .NUM_FEATURES (NUM_FEATURES),
        .WEIGHT_DEPTH (WEIGHT_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_en),
        .wr_addr (weight_addr),
        .wr_data (weight_value),
        .feat_en (start),
        .feats   (feats),
        .issue   (issue),
        .status  (status)
    );

    // The pipeline is empty whenever the sequencer waits for a word.
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !status.busy)
        else $error("pipeline busy while the sequencer is idle");

    // Terms are only issued while a classify is at work.
    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> in_stall)
        else $error("term issued while idle");

    // A result is only presented once the pipeline has drained.
    a_out_drained: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!status.busy))
        else $error("result presented before the pipeline drained");

endmodule
